[hw/rtl/dsam_pkg.sv]
// Shared types, command and register codes, and reset constants for the
// dual sensor alarm monitor. Depends on nothing.
`timescale 1ns / 1ps

package dsam_pkg;

	// channel and system state encoding
	typedef enum logic [1:0] {
		ST_NORMAL  = 2'd0,
		ST_WARNING = 2'd1,
		ST_ALARM   = 2'd2,
		ST_FAULT   = 2'd3
	} state_t;

	// request kinds carried in s_tuser
	typedef enum logic [1:0] {
		CMD_MOTION     = 2'd0,
		CMD_ENV        = 2'd1,
		CMD_MOTION_HLT = 2'd2,
		CMD_ENV_HLT    = 2'd3
	} cmd_t;

	// register indexes
	localparam int unsigned REG_VIB   = 0;
	localparam int unsigned REG_ROT   = 1;
	localparam int unsigned REG_TEMP  = 2;
	localparam int unsigned REG_HUM   = 3;
	localparam int unsigned REG_PRESS = 4;
	localparam int unsigned REG_HOLD  = 5;

	localparam int unsigned ADDR_W = 5;

	// register reset values
	localparam logic [31:0] RST_VIB   = 32'd32768200;
	localparam logic [31:0] RST_ROT   = 32'd131073000;
	localparam logic [31:0] RST_TEMP  = 32'd45875700;
	localparam logic [31:0] RST_HUM   = 32'd55706300;
	localparam logic [31:0] RST_PRESS = 32'd589833500;
	localparam logic [31:0] RST_HOLD  = 32'd13107300;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [31:0] vib;
		logic [31:0] rot;
		logic [31:0] temp;
		logic [31:0] hum;
		logic [31:0] press;
		logic [31:0] hold;
	} cfg_t;

	// per channel control from the datapath
	typedef struct packed {
		logic sample;
		logic health;
		logic healthy;
		logic warn;
		logic alarm;
	} chan_ctl_t;

	// per channel status after the update
	typedef struct packed {
		state_t state;
		logic   ok;
	} chan_stat_t;

endpackage

[hw/rtl/dual_sensor_alarm_monitor.sv]
// Dual sensor alarm monitor top level: input register, condition compare,
// two channel units, overall state and result register.
// Depends on dsam_pkg, dsam_cfg, dsam_chan.
//
// Usage: requests enter on the s_ stream; s_tuser selects motion sample,
// environment sample, motion health or environment health. Every request
// yields one result on the m_ stream with the overall state, both channel
// states and both health flags. A request moves into an input register,
// then the compare and state update run combinationally into the result
// register, which holds the result on m_ until it is taken; one request
// is taken every cycle while the receiver keeps up.
// The channel state registers update in the same
// cycle the result is registered, so the next request sees them at once.
// When the receiver stalls, the result register holds and the input
// register fills; s_tready drops only when both are full. Reset clears
// all states to normal, health flags to unhealthy, timers to idle and
// loads the register reset values. Configuration is written over APB
// with pready always high; write only while no request is in flight.
`timescale 1ns / 1ps

module dual_sensor_alarm_monitor (
	input  logic                         clk,
	input  logic                         arst_n,
	// apb configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsam_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// request stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// accel_mg[15:0], rotation_tenths[31:16], temperature_tenths[42:32],
	// humidity_tenths[52:43], pressure_tenths[66:53], time_ms[98:67],
	// healthy[99], zero fill[103:100]
	input  logic [103:0]                 s_tdata,
	// cmd[1:0]
	input  logic [1:0]                   s_tuser,
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// overall_state[1:0], motion_channel_state[3:2], env_channel_state[5:4],
	// motion_ok[6], env_ok[7]
	output logic [7:0]                   m_tdata
);
	import dsam_pkg::*;

	cfg_t        cfg;
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [99:0] data_s1;
	logic        advance;
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	state_t      overall_q;
	state_t      overall_d;

	logic [15:0]        accel;
	logic [15:0]        rot;
	logic signed [15:0] temp;
	logic [9:0]         hum;
	logic [13:0]        press;
	logic [31:0]        now;
	logic               healthy;

	logic       m_warn;
	logic       m_alarm;
	logic       e_warn;
	logic       e_alarm;
	chan_ctl_t  m_ctl;
	chan_ctl_t  e_ctl;
	chan_stat_t m_stat;
	chan_stat_t e_stat;

	dsam_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipeline handshake
	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			data_s1 <= s_tdata[99:0];
		end
	end

	// field unpack
	assign accel   = data_s1[15:0];
	assign rot     = data_s1[31:16];
	assign temp    = {{5{data_s1[42]}}, data_s1[42:32]};
	assign hum     = data_s1[52:43];
	assign press   = data_s1[66:53];
	assign now     = data_s1[98:67];
	assign healthy = data_s1[99];

	// limit compares
	assign m_warn  = (accel >= cfg.vib[15:0])  || (rot >= cfg.rot[15:0]);
	assign m_alarm = (accel >= cfg.vib[31:16]) || (rot >= cfg.rot[31:16]);
	assign e_warn  = (temp >= $signed(cfg.temp[15:0]))
		|| ({6'd0, hum} >= cfg.hum[15:0])
		|| ({2'd0, press} <= cfg.press[15:0]);
	assign e_alarm = (temp >= $signed(cfg.temp[31:16]))
		|| ({6'd0, hum} >= cfg.hum[31:16])
		|| ({2'd0, press} <= cfg.press[31:16]);

	// channel control
	always_comb begin
		m_ctl.sample  = advance && (cmd_s1 == CMD_MOTION);
		m_ctl.health  = advance && (cmd_s1 == CMD_MOTION_HLT);
		m_ctl.healthy = healthy;
		m_ctl.warn    = m_warn;
		m_ctl.alarm   = m_alarm;
		e_ctl.sample  = advance && (cmd_s1 == CMD_ENV);
		e_ctl.health  = advance && (cmd_s1 == CMD_ENV_HLT);
		e_ctl.healthy = healthy;
		e_ctl.warn    = e_warn;
		e_ctl.alarm   = e_alarm;
	end

	dsam_chan u_motion (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (m_ctl),
		.now        (now),
		.warn_hold  (cfg.hold[15:0]),
		.alarm_hold (cfg.hold[31:16]),
		.stat_nxt   (m_stat)
	);

	dsam_chan u_env (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (e_ctl),
		.now        (now),
		.warn_hold  (cfg.hold[15:0]),
		.alarm_hold (cfg.hold[31:16]),
		.stat_nxt   (e_stat)
	);

	// worst case system state, recomputed on samples only
	always_comb begin
		overall_d = overall_q;
		if (m_ctl.sample || e_ctl.sample) begin
			priority if (!m_stat.ok || !e_stat.ok)
				overall_d = ST_FAULT;
			else if (m_stat.state == ST_ALARM || e_stat.state == ST_ALARM)
				overall_d = ST_ALARM;
			else if (m_stat.state == ST_WARNING || e_stat.state == ST_WARNING)
				overall_d = ST_WARNING;
			else
				overall_d = ST_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overall_q <= ST_NORMAL;
		end else if (advance) begin
			overall_q <= overall_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			m_tdata_q <= {e_stat.ok, m_stat.ok, e_stat.state, m_stat.state, overall_d};
	end

endmodule

[hw/rtl/dsam_cfg.sv]
// APB register file holding limits and hold times.
// Depends on dsam_pkg.
`timescale 1ns / 1ps

module dsam_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsam_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output dsam_pkg::cfg_t               cfg
);
	import dsam_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vib   <= RST_VIB;
			cfg_q.rot   <= RST_ROT;
			cfg_q.temp  <= RST_TEMP;
			cfg_q.hum   <= RST_HUM;
			cfg_q.press <= RST_PRESS;
			cfg_q.hold  <= RST_HOLD;
		end else if (wr_en) begin
			unique case (idx)
				3'(REG_VIB):   cfg_q.vib   <= pwdata;
				3'(REG_ROT):   cfg_q.rot   <= pwdata;
				3'(REG_TEMP):  cfg_q.temp  <= pwdata;
				3'(REG_HUM):   cfg_q.hum   <= pwdata;
				3'(REG_PRESS): cfg_q.press <= pwdata;
				3'(REG_HOLD):  cfg_q.hold  <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (idx)
				3'(REG_VIB):   prdata = cfg_q.vib;
				3'(REG_ROT):   prdata = cfg_q.rot;
				3'(REG_TEMP):  prdata = cfg_q.temp;
				3'(REG_HUM):   prdata = cfg_q.hum;
				3'(REG_PRESS): prdata = cfg_q.press;
				3'(REG_HOLD):  prdata = cfg_q.hold;
				default:       prdata = '0;
			endcase
		end
	end

endmodule

[hw/rtl/dsam_chan.sv]
// One monitor channel: persistence timers, channel state and health flag.
// Depends on dsam_pkg.
`timescale 1ns / 1ps

module dsam_chan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dsam_pkg::chan_ctl_t   ctl,
	input  logic [31:0]           now,
	input  logic [15:0]           warn_hold,
	input  logic [15:0]           alarm_hold,
	output dsam_pkg::chan_stat_t  stat_nxt
);
	import dsam_pkg::*;

	state_t      state_q;
	logic        ok_q;
	logic        a_pend_q;
	logic        w_pend_q;
	logic [31:0] a_stamp_q;
	logic [31:0] w_stamp_q;

	logic        warn_only;
	logic [31:0] a_elapsed;
	logic [31:0] w_elapsed;
	state_t      state_d;
	logic        ok_d;

	assign warn_only = ctl.warn && !ctl.alarm;
	// a fresh timer starts at zero elapsed
	assign a_elapsed = a_pend_q ? (now - a_stamp_q) : '0;
	assign w_elapsed = w_pend_q ? (now - w_stamp_q) : '0;

	// next channel state and health
	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		if (ctl.sample) begin
			if (ctl.alarm) begin
				if (a_elapsed >= {16'd0, alarm_hold})
					state_d = ST_ALARM;
			end else if (warn_only) begin
				if (w_elapsed >= {16'd0, warn_hold})
					state_d = ST_WARNING;
			end else begin
				state_d = ST_NORMAL;
			end
		end else if (ctl.health) begin
			ok_d = ctl.healthy;
			if (!ctl.healthy)
				state_d = ST_FAULT;
		end
	end

	assign stat_nxt.state = state_d;
	assign stat_nxt.ok    = ok_d;

	// state and health registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NORMAL;
			ok_q    <= 1'b0;
		end else if (ctl.sample || ctl.health) begin
			state_q <= state_d;
			ok_q    <= ok_d;
		end
	end

	// pending flags, warning timing held off while an alarm condition stands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_pend_q <= 1'b0;
			w_pend_q <= 1'b0;
		end else if (ctl.sample) begin
			a_pend_q <= ctl.alarm;
			w_pend_q <= warn_only;
		end
	end

	// start stamps latched when a timer starts
	always_ff @(posedge clk) begin
		if (ctl.sample && ctl.alarm && !a_pend_q)
			a_stamp_q <= now;
		if (ctl.sample && warn_only && !w_pend_q)
			w_stamp_q <= now;
	end

endmodule
